[sv/rrs_pkg.sv]
`default_nettype none
package rrs_pkg;

	// Field and state widths
	localparam int BYTE_W     = 8;
	localparam int TICK_W     = 7;
	localparam int IR_SUM_W   = 12;
	localparam int BAT_SUM_W  = 10;
	localparam int FUNC_W     = 2;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// Default run lengths
	localparam int IR_PAIRS_DEF    = 10;
	localparam int BAT_SAMPLES_DEF = 4;

	// Register reset values
	localparam logic [BYTE_W-1:0] PAIR_TOL_RST  = 8'd3;
	localparam logic [BYTE_W-1:0] WIN_LOW_RST   = 8'd20;
	localparam logic [BYTE_W-1:0] WIN_HIGH_RST  = 8'd61;
	localparam logic [BYTE_W-1:0] BAT_THR_RST   = 8'd160;
	localparam logic [TICK_W-1:0] TICK_PER_RST  = 7'd100;
	localparam logic [BYTE_W-1:0] STOP_CODE_RST = 8'h31;
	localparam logic [BYTE_W-1:0] DUTY_RST      = 8'd30;

	// Item kinds carried on the input tuser
	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_IR     = 2'd1,
		FUNC_BAT    = 2'd2,
		FUNC_BUTTON = 2'd3
	} func_t;

	// Register word indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_PAIR_TOL  = 3'd0,
		REG_WIN_LOW   = 3'd1,
		REG_WIN_HIGH  = 3'd2,
		REG_BAT_THR   = 3'd3,
		REG_TICK_PER  = 3'd4,
		REG_STOP_CODE = 3'd5,
		REG_DUTY      = 3'd6
	} reg_idx_t;

	// Result item, first field in the highest bits
	typedef struct packed {
		logic [BYTE_W-1:0] led_pattern;
		logic [BYTE_W-1:0] battery_avg;
		logic              battery_valid;
		logic [BYTE_W-1:0] distance_avg;
		logic              distance_valid;
		logic              battery_request;
		logic              stop_line;
		logic [BYTE_W-1:0] motor_duty;
		logic              motors_on;
		logic              run_on;
	} result_t;

endpackage
`default_nettype wire

[sv/robot_run_supervisor_top.sv]
// Robot run supervisor.
// Input stream (s_*): one item per transfer. s_tuser carries the item kind
// (tick, IR pair, battery sample, remote button); s_tdata carries the IR
// pair, battery sample and button byte. Every item gives exactly one result
// on the output stream (m_*): run and motor state, motor duty, stop line,
// the battery request, distance and battery completion pulses, the latest
// averages and the LED pattern.
// m_tvalid rises once the item has passed the input register, then the result register;
// the result then stays offered until m_tready takes it.
// Throughput is one item per cycle while the receiver keeps m_tready high;
// all the work for an item is one pass of logic, of which the longest path
// is the IR midpoint add into a constant reciprocal multiply and the window
// compare.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; after that s_tready falls until the
// result is taken.
// Settings are to be written over the APB port only while the block is idle; the
// block does not enforce this. pready is always high and reads return the register value.
// Reset loads the settings defaults, clears the counters, sums and
// averages, stops run and motors and raises the stop line.
`default_nettype none
module robot_run_supervisor_top #(
	parameter int IR_PAIRS    = rrs_pkg::IR_PAIRS_DEF,
	parameter int BAT_SAMPLES = rrs_pkg::BAT_SAMPLES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [7:0] ir_first, [15:8] ir_second, [23:16] battery_sample, [31:24] button_code
	input  wire logic [rrs_pkg::IN_DATA_W-1:0]   s_tdata,
	// [1:0] func
	input  wire logic [rrs_pkg::FUNC_W-1:0]      s_tuser,
	// output stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [0] run_on, [1] motors_on, [9:2] motor_duty, [10] stop_line,
	// [11] battery_request, [12] distance_valid, [20:13] distance_avg,
	// [21] battery_valid, [29:22] battery_avg, [37:30] led_pattern, [39:38] zero
	output logic [rrs_pkg::OUT_DATA_W-1:0]       m_tdata,
	// configuration port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [rrs_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [rrs_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [rrs_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	localparam int BW = rrs_pkg::BYTE_W;
	localparam int TW = rrs_pkg::TICK_W;
	localparam int IR_CNT_W  = (IR_PAIRS > 1) ? $clog2(IR_PAIRS) : 1;
	localparam int BAT_CNT_W = (BAT_SAMPLES > 1) ? $clog2(BAT_SAMPLES) : 1;
	// reciprocal divide, exact over the whole sum range
	localparam int IR_SHIFT  = rrs_pkg::IR_SUM_W + IR_CNT_W;
	localparam int IR_PROD_W = rrs_pkg::IR_SUM_W + IR_SHIFT + 1;
	localparam logic [IR_SHIFT:0] IR_RECIP =
		(IR_SHIFT+1)'((2**IR_SHIFT + IR_PAIRS - 1) / IR_PAIRS);
	localparam int BAT_SHIFT  = rrs_pkg::BAT_SUM_W + BAT_CNT_W;
	localparam int BAT_PROD_W = rrs_pkg::BAT_SUM_W + BAT_SHIFT + 1;
	localparam logic [BAT_SHIFT:0] BAT_RECIP =
		(BAT_SHIFT+1)'((2**BAT_SHIFT + BAT_SAMPLES - 1) / BAT_SAMPLES);
	localparam logic [IR_CNT_W:0]  IR_RUN  = (IR_CNT_W+1)'(IR_PAIRS);
	localparam logic [BAT_CNT_W:0] BAT_RUN = (BAT_CNT_W+1)'(BAT_SAMPLES);

	// settings registers
	logic [BW-1:0] pair_tol_q, win_low_q, win_high_q, bat_thr_q, stop_code_q, duty_q;
	logic [TW-1:0] tick_per_q;

	// supervisor state
	logic                          run_q, motor_q, stop_q;
	logic [TW-1:0]                 tick_q;
	logic [rrs_pkg::IR_SUM_W-1:0]  ir_sum_q;
	logic [IR_CNT_W-1:0]           ir_cnt_q;
	logic [rrs_pkg::BAT_SUM_W-1:0] bat_sum_q;
	logic [BAT_CNT_W-1:0]          bat_cnt_q;
	logic [BW-1:0]                 dist_q, batt_q, led_q;

	// next state
	logic                          run_d, motor_d, stop_d;
	logic [TW-1:0]                 tick_d;
	logic [rrs_pkg::IR_SUM_W-1:0]  ir_sum_d;
	logic [IR_CNT_W-1:0]           ir_cnt_d;
	logic [rrs_pkg::BAT_SUM_W-1:0] bat_sum_d;
	logic [BAT_CNT_W-1:0]          bat_cnt_d;
	logic [BW-1:0]                 dist_d, batt_d, led_d;
	logic                          breq, dvalid, bvalid;

	// pipeline
	logic                          valid_s1;
	rrs_pkg::func_t                func_s1;
	logic [BW-1:0]                 ir_first_s1, ir_second_s1, bat_s1, btn_s1;
	logic                          valid_s2;
	rrs_pkg::result_t              res_s2;
	rrs_pkg::result_t              res_d;
	logic                          adv_s1;

	// item datapath
	logic [BW:0]                   pair_diff, pair_add;
	logic                          pair_ok;
	logic [rrs_pkg::IR_SUM_W-1:0]  ir_sum_nx;
	logic [IR_CNT_W:0]             ir_cnt_inc;
	logic [IR_PROD_W-1:0]          ir_prod;
	logic [BW-1:0]                 ir_avg;
	logic [rrs_pkg::BAT_SUM_W-1:0] bat_sum_nx;
	logic [BAT_CNT_W:0]            bat_cnt_inc;
	logic [BAT_PROD_W-1:0]         bat_prod;
	logic [BW-1:0]                 bat_avg;
	logic [TW:0]                   tick_inc;
	logic                          cfg_wr;
	rrs_pkg::reg_idx_t             cfg_idx;

	// handshake: input stage moves when the result register is free or drained
	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(rrs_pkg::OUT_DATA_W-$bits(rrs_pkg::result_t)){1'b0}}, res_s2};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1      <= rrs_pkg::func_t'(s_tuser);
			ir_first_s1  <= s_tdata[BW-1:0];
			ir_second_s1 <= s_tdata[2*BW-1:BW];
			bat_s1       <= s_tdata[3*BW-1:2*BW];
			btn_s1       <= s_tdata[4*BW-1:3*BW];
		end
	end

	// shared arithmetic for the item in the input register
	assign tick_inc    = {1'b0, tick_q} + (TW+1)'(1);
	assign pair_diff   = {1'b0, ir_second_s1} - {1'b0, ir_first_s1};
	assign pair_ok     = !pair_diff[BW] && (pair_diff[BW-1:0] < pair_tol_q);
	assign pair_add    = {1'b0, ir_first_s1} + {1'b0, ir_second_s1};
	assign ir_sum_nx   = ir_sum_q + rrs_pkg::IR_SUM_W'(pair_add[BW:1]);
	assign ir_cnt_inc  = {1'b0, ir_cnt_q} + (IR_CNT_W+1)'(1);
	assign ir_prod     = IR_PROD_W'(ir_sum_nx) * IR_PROD_W'(IR_RECIP);
	assign ir_avg      = ir_prod[IR_SHIFT +: BW];
	assign bat_sum_nx  = bat_sum_q + rrs_pkg::BAT_SUM_W'(bat_s1);
	assign bat_cnt_inc = {1'b0, bat_cnt_q} + (BAT_CNT_W+1)'(1);
	assign bat_prod    = BAT_PROD_W'(bat_sum_nx) * BAT_PROD_W'(BAT_RECIP);
	assign bat_avg     = bat_prod[BAT_SHIFT +: BW];

	// next state and result for one item
	always_comb begin
		run_d     = run_q;
		motor_d   = motor_q;
		stop_d    = stop_q;
		tick_d    = tick_q;
		ir_sum_d  = ir_sum_q;
		ir_cnt_d  = ir_cnt_q;
		bat_sum_d = bat_sum_q;
		bat_cnt_d = bat_cnt_q;
		dist_d    = dist_q;
		batt_d    = batt_q;
		led_d     = led_q;
		breq      = 1'b0;
		dvalid    = 1'b0;
		bvalid    = 1'b0;
		case (func_s1)
			rrs_pkg::FUNC_TICK: begin
				if (tick_inc > {1'b0, tick_per_q}) begin
					breq   = 1'b1;
					tick_d = '0;
				end else begin
					tick_d = tick_inc[TW-1:0];
				end
			end
			rrs_pkg::FUNC_IR: begin
				if (pair_ok) begin
					if (ir_cnt_inc >= IR_RUN) begin
						dist_d   = ir_avg;
						led_d    = ~ir_second_s1;
						dvalid   = 1'b1;
						ir_sum_d = '0;
						ir_cnt_d = '0;
						// window check; a value on a bound leaves the motors
						if ((ir_avg < win_low_q || ir_avg > win_high_q) && motor_q) begin
							motor_d = 1'b0;
						end else if (ir_avg > win_low_q && ir_avg < win_high_q && !motor_q) begin
							motor_d = 1'b1;
						end
					end else begin
						ir_sum_d = ir_sum_nx;
						ir_cnt_d = ir_cnt_inc[IR_CNT_W-1:0];
					end
				end
			end
			rrs_pkg::FUNC_BAT: begin
				if (bat_cnt_inc >= BAT_RUN) begin
					batt_d    = bat_avg;
					bvalid    = 1'b1;
					bat_sum_d = '0;
					bat_cnt_d = '0;
					// low battery while running stops everything
					if (bat_avg < bat_thr_q && run_q) begin
						run_d   = 1'b0;
						motor_d = 1'b0;
						stop_d  = 1'b1;
					end
				end else begin
					bat_sum_d = bat_sum_nx;
					bat_cnt_d = bat_cnt_inc[BAT_CNT_W-1:0];
				end
			end
			rrs_pkg::FUNC_BUTTON: begin
				if (btn_s1 == stop_code_q) begin
					run_d   = !run_q;
					motor_d = !run_q;
					stop_d  = run_q;
				end
			end
			default: begin
			end
		endcase

		res_d.run_on          = run_d;
		res_d.motors_on       = motor_d;
		res_d.motor_duty      = motor_d ? duty_q : '0;
		res_d.stop_line       = stop_d;
		res_d.battery_request = breq;
		res_d.distance_valid  = dvalid;
		res_d.distance_avg    = dist_d;
		res_d.battery_valid   = bvalid;
		res_d.battery_avg     = batt_d;
		res_d.led_pattern     = led_d;
	end

	// state update as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			motor_q   <= 1'b0;
			stop_q    <= 1'b1;
			tick_q    <= '0;
			ir_sum_q  <= '0;
			ir_cnt_q  <= '0;
			bat_sum_q <= '0;
			bat_cnt_q <= '0;
			dist_q    <= '0;
			batt_q    <= '0;
			led_q     <= '0;
		end else if (valid_s1 && adv_s1) begin
			run_q     <= run_d;
			motor_q   <= motor_d;
			stop_q    <= stop_d;
			tick_q    <= tick_d;
			ir_sum_q  <= ir_sum_d;
			ir_cnt_q  <= ir_cnt_d;
			bat_sum_q <= bat_sum_d;
			bat_cnt_q <= bat_cnt_d;
			dist_q    <= dist_d;
			batt_q    <= batt_d;
			led_q     <= led_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = rrs_pkg::reg_idx_t'(paddr[rrs_pkg::APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_tol_q  <= rrs_pkg::PAIR_TOL_RST;
			win_low_q   <= rrs_pkg::WIN_LOW_RST;
			win_high_q  <= rrs_pkg::WIN_HIGH_RST;
			bat_thr_q   <= rrs_pkg::BAT_THR_RST;
			tick_per_q  <= rrs_pkg::TICK_PER_RST;
			stop_code_q <= rrs_pkg::STOP_CODE_RST;
			duty_q      <= rrs_pkg::DUTY_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				rrs_pkg::REG_PAIR_TOL:  pair_tol_q  <= pwdata[BW-1:0];
				rrs_pkg::REG_WIN_LOW:   win_low_q   <= pwdata[BW-1:0];
				rrs_pkg::REG_WIN_HIGH:  win_high_q  <= pwdata[BW-1:0];
				rrs_pkg::REG_BAT_THR:   bat_thr_q   <= pwdata[BW-1:0];
				rrs_pkg::REG_TICK_PER:  tick_per_q  <= pwdata[TW-1:0];
				rrs_pkg::REG_STOP_CODE: stop_code_q <= pwdata[BW-1:0];
				rrs_pkg::REG_DUTY:      duty_q      <= pwdata[BW-1:0];
				default: begin
				end
			endcase
		end
	end

	// register read-back
	always_comb begin
		case (cfg_idx)
			rrs_pkg::REG_PAIR_TOL:  prdata = rrs_pkg::APB_DATA_W'(pair_tol_q);
			rrs_pkg::REG_WIN_LOW:   prdata = rrs_pkg::APB_DATA_W'(win_low_q);
			rrs_pkg::REG_WIN_HIGH:  prdata = rrs_pkg::APB_DATA_W'(win_high_q);
			rrs_pkg::REG_BAT_THR:   prdata = rrs_pkg::APB_DATA_W'(bat_thr_q);
			rrs_pkg::REG_TICK_PER:  prdata = rrs_pkg::APB_DATA_W'(tick_per_q);
			rrs_pkg::REG_STOP_CODE: prdata = rrs_pkg::APB_DATA_W'(stop_code_q);
			rrs_pkg::REG_DUTY:      prdata = rrs_pkg::APB_DATA_W'(duty_q);
			default:                prdata = '0;
		endcase
	end

	// stop line always mirrors a stopped run state
	a_stop_mirrors_run: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q == !run_q)
		else $error("stop indicator out of step with run state");

	// a battery request leaves the tick divider at zero
	a_tick_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1 && breq) |=> (tick_q == '0))
		else $error("tick divider did not wrap on battery request");

	// duty is only driven while the motors run
	a_duty_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.motors_on) |-> (res_s2.motor_duty == '0))
		else $error("motor duty set with motors off");

	// a completed IR run clears the pair counter
	a_ir_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1 && dvalid) |=> (ir_cnt_q == '0 && ir_sum_q == '0))
		else $error("IR accumulator not cleared after distance average");

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

	localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up
	localparam int LONG_HOLD   = 400;   // receiver back-pressure stretch
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 200;
	localparam int N_DIRECTED  = 25;
	localparam int BW          = rrs_pkg::BYTE_W;

	// Directed row: item fields, then an optional pinned result (flags and duty only,
	// averages and LED pattern still zero at that point)
	typedef struct packed {
		rrs_pkg::func_t    f;
		logic [BW-1:0]     a;
		logic [BW-1:0]     b;
		logic [BW-1:0]     bat;
		logic [BW-1:0]     btn;
		logic              pin;
		logic              run;
		logic              mot;
		logic [BW-1:0]     duty;
		logic              stop;
	} probe_t;

	typedef struct {
		bit               pin;
		rrs_pkg::result_t res;
	} pinned_t;

	typedef struct {
		logic [BW-1:0]              tol;
		logic [BW-1:0]              wlo;
		logic [BW-1:0]              whi;
		logic [BW-1:0]              thr;
		logic [rrs_pkg::TICK_W-1:0] per;
		logic [BW-1:0]              code;
		logic [BW-1:0]              duty;
	} settings_t;

	// Reset settings: tick, mismatched and matching stop codes, wrapped, reversed and
	// just-too-wide pairs, ten pairs averaging onto the lower window bound, a low
	// battery while running, a low battery while stopped, and a restart.
	localparam probe_t DIRECTED [N_DIRECTED] = '{
		'{rrs_pkg::FUNC_TICK,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 8'd0,  1'b1},
		'{rrs_pkg::FUNC_BUTTON, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, 8'd0,  1'b1},
		'{rrs_pkg::FUNC_BUTTON, 8'h00, 8'h00, 8'h00, 8'h31, 1'b1, 1'b1, 1'b1, 8'd30, 1'b0},
		'{rrs_pkg::FUNC_IR,     8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 8'd30, 1'b0},
		'{rrs_pkg::FUNC_IR,     8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 8'd30, 1'b0},
		'{rrs_pkg::FUNC_IR,     8'd10, 8'd13, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 8'd30, 1'b0},
		'{rrs_pkg::FUNC_IR,     8'd20, 8'd20, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_IR,     8'd20, 8'd20, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_IR,     8'd20, 8'd20, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_IR,     8'd20, 8'd20, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_IR,     8'd20, 8'd20, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_IR,     8'd20, 8'd20, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_IR,     8'd20, 8'd20, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_IR,     8'd20, 8'd20, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_IR,     8'd20, 8'd20, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_IR,     8'd20, 8'd22, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_BAT,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_BAT,    8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_BAT,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_BAT,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_BAT,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_BAT,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_BAT,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_BAT,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0},
		'{rrs_pkg::FUNC_BUTTON, 8'h00, 8'h00, 8'h00, 8'h31, 1'b0, 1'b0, 1'b0, 8'd0,  1'b0}
	};

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [rrs_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
	logic [rrs_pkg::FUNC_W-1:0]     s_tuser  = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [rrs_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           psel     = 1'b0;
	logic                           penable  = 1'b0;
	logic                           pwrite   = 1'b0;
	logic [rrs_pkg::APB_ADDR_W-1:0] paddr    = '0;
	logic [rrs_pkg::APB_DATA_W-1:0] pwdata   = '0;
	logic [rrs_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	robot_run_supervisor_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mirror of the block's settings and state
	settings_t                  settings;
	logic                       run_st, motor_st, stop_st;
	logic [rrs_pkg::TICK_W-1:0] tick_cnt;
	logic [11:0]                ir_acc;
	int unsigned                ir_n, bat_n;
	logic [9:0]                 bat_acc;
	logic [BW-1:0]              dist_last, bat_last, led_last;

	rrs_pkg::result_t expected_res[$];
	pinned_t pinned_q[$];
	int      errors       = 0;
	int      snd_idle_pct = 0;
	int      rcv_idle_pct = 0;
	bit      long_hold    = 0;
	int      ir_aim       = 0;
	int      ir_made      = 0;

	function automatic void toggle_run();
		run_st   = ~run_st;
		motor_st = run_st;
		stop_st  = ~run_st;
	endfunction

	// Advance the mirror by one item and return the status it should report
	function automatic rrs_pkg::result_t supervise(rrs_pkg::func_t f, logic [7:0] a,
			logic [7:0] b, logic [7:0] bat, logic [7:0] btn);
		rrs_pkg::result_t r;
		logic [15:0] diff;
		logic [7:0]  avg;
		int unsigned nxt;
		r = '0;
		case (f)
			rrs_pkg::FUNC_TICK: begin
				nxt = int'(tick_cnt) + 1;
				if (nxt > int'(settings.per)) begin
					r.battery_request = 1'b1;
					tick_cnt = '0;
				end else begin
					tick_cnt = nxt[rrs_pkg::TICK_W-1:0];
				end
			end
			rrs_pkg::FUNC_IR: begin
				diff = {8'd0, b} - {8'd0, a};
				if (diff < {8'd0, settings.tol}) begin
					ir_acc = ir_acc + 12'(({1'b0, a} + {1'b0, b}) >> 1);
					ir_n++;
					if (ir_n >= rrs_pkg::IR_PAIRS_DEF) begin
						avg = 8'(ir_acc / rrs_pkg::IR_PAIRS_DEF);
						dist_last = avg;
						led_last = ~b;
						r.distance_valid = 1'b1;
						ir_acc = '0;
						ir_n = 0;
						if ((avg < settings.wlo || avg > settings.whi) && motor_st)
							motor_st = 1'b0;
						else if (avg > settings.wlo && avg < settings.whi && !motor_st)
							motor_st = 1'b1;
					end
				end
			end
			rrs_pkg::FUNC_BAT: begin
				bat_acc = bat_acc + 10'(bat);
				bat_n++;
				if (bat_n >= rrs_pkg::BAT_SAMPLES_DEF) begin
					avg = 8'(bat_acc / rrs_pkg::BAT_SAMPLES_DEF);
					bat_last = avg;
					r.battery_valid = 1'b1;
					bat_acc = '0;
					bat_n = 0;
					if (avg < settings.thr && run_st)
						toggle_run();
				end
			end
			default: begin
				if (btn == settings.code)
					toggle_run();
			end
		endcase
		r.run_on       = run_st;
		r.motors_on    = motor_st;
		r.motor_duty   = motor_st ? settings.duty : 8'd0;
		r.stop_line    = stop_st;
		r.distance_avg = dist_last;
		r.battery_avg  = bat_last;
		r.led_pattern  = led_last;
		return r;
	endfunction

	function automatic int pick_gap(int pct);
		if (int'($urandom_range(0, 99)) >= pct)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(5, 30));
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Input transfers: predict at acceptance; a row that pins its result uses that instead
	always @(posedge clk) begin : intake
		rrs_pkg::result_t pred;
		pinned_t pin;
		if (arst_n && s_tvalid && s_tready) begin
			pred = supervise(rrs_pkg::func_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
				s_tdata[23:16], s_tdata[31:24]);
			pin = pinned_q.pop_front();
			expected_res.push_back(pin.pin ? pin.res : pred);
		end
	end

	// Output transfers: compare with the oldest expectation
	always @(posedge clk) begin : outlet
		rrs_pkg::result_t got;
		rrs_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(rrs_pkg::result_t)-1:0];
			check_field("padding", 0,
				m_tdata[rrs_pkg::OUT_DATA_W-1:$bits(rrs_pkg::result_t)]);
			if (expected_res.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, m_tdata);
			end else begin
				want = expected_res.pop_front();
				check_field("run_on", want.run_on, got.run_on);
				check_field("motors_on", want.motors_on, got.motors_on);
				check_field("motor_duty", want.motor_duty, got.motor_duty);
				check_field("stop_line", want.stop_line, got.stop_line);
				check_field("battery_request", want.battery_request, got.battery_request);
				check_field("distance_valid", want.distance_valid, got.distance_valid);
				check_field("distance_avg", want.distance_avg, got.distance_avg);
				check_field("battery_valid", want.battery_valid, got.battery_valid);
				check_field("battery_avg", want.battery_avg, got.battery_avg);
				check_field("led_pattern", want.led_pattern, got.led_pattern);
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold on request
	initial begin : receiver
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 0;
			end
			n = pick_gap(rcv_idle_pct);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Watchdog on cycles with no transfer anywhere
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: timeout, %0d results outstanding", $time, expected_res.size());
		$display("robot_run_supervisor_top test failed");
		$finish;
	end

	// One input transfer, after an optional gap
	task automatic send_item(rrs_pkg::func_t f, logic [rrs_pkg::IN_DATA_W-1:0] data);
		int n;
		n = pick_gap(snd_idle_pct);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering and wait until every result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (expected_res.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Setup phase and access phase, then an idle bus before the next write
	task automatic reg_write(rrs_pkg::reg_idx_t idx, logic [rrs_pkg::APB_DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(settings_t c);
		reg_write(rrs_pkg::REG_PAIR_TOL, 32'(c.tol));
		reg_write(rrs_pkg::REG_WIN_LOW, 32'(c.wlo));
		reg_write(rrs_pkg::REG_WIN_HIGH, 32'(c.whi));
		reg_write(rrs_pkg::REG_BAT_THR, 32'(c.thr));
		reg_write(rrs_pkg::REG_TICK_PER, 32'(c.per));
		reg_write(rrs_pkg::REG_STOP_CODE, 32'(c.code));
		reg_write(rrs_pkg::REG_DUTY, 32'(c.duty));
		settings = c;
	endtask

	// Random item: mostly well-formed IR pairs aimed at a bound or a random distance,
	// batteries near the threshold, and the stop code often enough to toggle the run
	task automatic make_item(output rrs_pkg::func_t f,
			output logic [rrs_pkg::IN_DATA_W-1:0] data);
		int pick, span, a, b, bat, btn;
		a    = int'($urandom_range(0, 255));
		b    = int'($urandom_range(0, 255));
		bat  = int'($urandom_range(0, 255));
		btn  = int'($urandom_range(0, 255));
		pick = int'($urandom_range(0, 99));
		if (pick < 25) begin
			f = rrs_pkg::FUNC_TICK;
		end else if (pick < 70) begin
			f = rrs_pkg::FUNC_IR;
			if (ir_made % rrs_pkg::IR_PAIRS_DEF == 0) begin
				case ($urandom_range(0, 3))
					0: ir_aim = int'(settings.wlo);
					1: ir_aim = int'(settings.whi);
					default: ir_aim = int'($urandom_range(0, 255));
				endcase
			end
			ir_made++;
			if ($urandom_range(0, 99) < 85) begin
				span = (settings.tol == 0) ? 0 : int'(settings.tol) - 1;
				a = (ir_aim + span > 255) ? 255 - span : ir_aim;
				b = a + int'($urandom_range(0, span));
			end
		end else if (pick < 88) begin
			f = rrs_pkg::FUNC_BAT;
			if ($urandom_range(0, 1) == 0) begin
				bat = int'(settings.thr) + int'($urandom_range(0, 16)) - 8;
				bat = (bat < 0) ? 0 : (bat > 255) ? 255 : bat;
			end
		end else begin
			f = rrs_pkg::FUNC_BUTTON;
			if ($urandom_range(0, 99) < 40)
				btn = int'(settings.code);
		end
		data = {btn[7:0], bat[7:0], b[7:0], a[7:0]};
	endtask

	initial begin : stimulus
		rrs_pkg::func_t                f;
		logic [rrs_pkg::IN_DATA_W-1:0] data;
		pinned_t                       pin;
		settings_t                     c;
		probe_t                        row;

		settings = '{rrs_pkg::PAIR_TOL_RST, rrs_pkg::WIN_LOW_RST, rrs_pkg::WIN_HIGH_RST,
			rrs_pkg::BAT_THR_RST, rrs_pkg::TICK_PER_RST, rrs_pkg::STOP_CODE_RST,
			rrs_pkg::DUTY_RST};
		run_st    = 1'b0;
		motor_st  = 1'b0;
		stop_st   = 1'b1;
		tick_cnt  = '0;
		ir_acc    = '0;
		ir_n      = 0;
		bat_acc   = '0;
		bat_n     = 0;
		dist_last = '0;
		bat_last  = '0;
		led_last  = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings
		snd_idle_pct = 15;
		rcv_idle_pct = 15;
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED[i];
			pin.pin = row.pin;
			pin.res = '0;
			pin.res.run_on     = row.run;
			pin.res.motors_on  = row.mot;
			pin.res.motor_duty = row.duty;
			pin.res.stop_line  = row.stop;
			pinned_q.push_back(pin);
			send_item(row.f, {row.btn, row.bat, row.b, row.a});
		end
		settle();

		// Random phases, each under its own settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: c = '{8'd0, 8'd0, 8'd255, 8'd255, 7'd0, 8'hFF, 8'd255};
				1: c = '{8'd255, 8'd255, 8'd0, 8'd0, 7'd126, 8'h00, 8'd0};
				2: c = '{8'd1, 8'd40, 8'd90, 8'd128, 7'd3, 8'h31, 8'd77};
				default: begin
					c.tol  = 8'($urandom_range(1, 6));
					c.wlo  = 8'($urandom_range(0, 120));
					c.whi  = c.wlo + 8'($urandom_range(0, 135));
					c.thr  = 8'($urandom_range(0, 255));
					c.per  = 7'($urandom_range(0, 15));
					c.code = 8'($urandom_range(0, 255));
					c.duty = 8'($urandom_range(0, 255));
				end
			endcase
			apply_settings(c);
			case (p)
				1: begin snd_idle_pct = 0;  rcv_idle_pct = 30; long_hold = 1; end
				2: begin snd_idle_pct = 30; rcv_idle_pct = 0;  end
				4: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
				5: begin snd_idle_pct = 50; rcv_idle_pct = 50; end
				default: begin snd_idle_pct = 20; rcv_idle_pct = 20; end
			endcase
			pin.pin = 1'b0;
			pin.res = '0;
			repeat (PHASE_ITEMS) begin
				make_item(f, data);
				pinned_q.push_back(pin);
				send_item(f, data);
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && expected_res.size() == 0)
			$display("robot_run_supervisor_top test passed");
		else
			$display("robot_run_supervisor_top test failed");
		$finish;
	end

endmodule

[files.f]
sv/rrs_pkg.sv
sv/robot_run_supervisor_top.sv
sim/tb.sv
